>>> rtl/core/lkvc_pkg.sv
// Shared constants, state type and controller command word for the LRU key-value cache.
package lkvc_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int OCC_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 31;
	localparam int CAP_W    = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAPACITY);

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_SET = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic latch;
		logic look;
		logic upd;
	} cmd_t;

endpackage

>>> rtl/core/lkvc_ctrl.sv
// Controller state machine: sequences accept, lookup and update of one word.
module lkvc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output lkvc_pkg::cmd_t cmd
);

	lkvc_pkg::state_t state_q;
	lkvc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lkvc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = lkvc_pkg::ST_LOOK;
				end
			end
			lkvc_pkg::ST_LOOK: begin
				state_d = lkvc_pkg::ST_UPD;
			end
			lkvc_pkg::ST_UPD: begin
				state_d = lkvc_pkg::ST_IDLE;
			end
			default: begin
				state_d = lkvc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		cmd.latch = 1'b0;
		cmd.look  = 1'b0;
		cmd.upd   = 1'b0;
		case (state_q)
			lkvc_pkg::ST_IDLE: begin
				busy      = 1'b0;
				cmd.latch = start;
			end
			lkvc_pkg::ST_LOOK: begin
				cmd.look = 1'b1;
			end
			lkvc_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

>>> rtl/core/lkvc_datapath.sv
// Datapath: entry store, parallel key compare, victim choice and recency update.
module lkvc_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lkvc_pkg::cmd_t                     cmd,
	input  logic                               cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]         cfg_wdata,
	input  logic                               mode,
	input  logic signed [lkvc_pkg::KEY_W-1:0]  key,
	input  logic [lkvc_pkg::VAL_W-1:0]         value,
	output logic                               done,
	output logic                               hit,
	output logic signed [lkvc_pkg::KEY_W-1:0]  read_value,
	output logic                               evicted,
	output logic signed [lkvc_pkg::KEY_W-1:0]  evicted_key
);

	localparam int N  = lkvc_pkg::CAPACITY;
	localparam int IW = lkvc_pkg::IDX_W;
	localparam int OW = lkvc_pkg::OCC_W;
	localparam int KW = lkvc_pkg::KEY_W;
	localparam int VW = lkvc_pkg::VAL_W;

	logic [lkvc_pkg::CAP_W-1:0] cap_q;
	logic [OW-1:0]              occ_q;
	logic [N-1:0]               valid_q;
	logic [KW-1:0]              key_mem_q [N];
	logic [VW-1:0]              val_mem_q [N];
	logic [IW-1:0]              rank_q    [N];

	logic          mode_q;
	logic [KW-1:0] key_q;
	logic [VW-1:0] val_q;

	logic          hit_s1;
	logic          ins_s1;
	logic          evict_s1;
	logic [IW-1:0] slot_s1;
	logic [OW:0]   old_s1;
	logic [KW-1:0] rd_s1;
	logic [KW-1:0] evk_s1;

	logic [OW-1:0] cap_eff;
	logic          full;
	logic [N-1:0]  match;
	logic          hit_c;
	logic [IW-1:0] hit_idx;
	logic [IW-1:0] vic_idx;
	logic [IW-1:0] free_idx;
	logic [OW-1:0] occ_m1;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = OW'(1);
		end else if ({1'b0, cap_q} > (lkvc_pkg::CAP_W + 1)'(N)) begin
			cap_eff = OW'(N);
		end else begin
			cap_eff = OW'(cap_q);
		end
	end

	assign full   = occ_q >= cap_eff;
	assign occ_m1 = occ_q - OW'(1);

	always_comb begin
		hit_c    = 1'b0;
		hit_idx  = '0;
		vic_idx  = '0;
		free_idx = '0;
		for (int j = N - 1; j >= 0; j--) begin
			match[j] = valid_q[j] && (key_mem_q[j] == key_q);
			if (match[j]) begin
				hit_c   = 1'b1;
				hit_idx = IW'(j);
			end
			if (!valid_q[j]) begin
				free_idx = IW'(j);
			end
			if (valid_q[j] && ({1'b0, rank_q[j]} == (IW + 1)'(occ_m1))) begin
				vic_idx = IW'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode;
			key_q  <= key;
			val_q  <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_s1   <= hit_c;
			ins_s1   <= hit_c || (mode_q == lkvc_pkg::MODE_SET);
			evict_s1 <= !hit_c && (mode_q == lkvc_pkg::MODE_SET) && full;
			rd_s1    <= (hit_c && (mode_q == lkvc_pkg::MODE_GET)) ?
			            {1'b0, val_mem_q[hit_idx]} : '1;
			evk_s1   <= (!hit_c && (mode_q == lkvc_pkg::MODE_SET) && full) ?
			            key_mem_q[vic_idx] : '0;
			if (hit_c) begin
				slot_s1 <= hit_idx;
				old_s1  <= (OW + 1)'(rank_q[hit_idx]);
			end else if (full) begin
				slot_s1 <= vic_idx;
				old_s1  <= (OW + 1)'(occ_m1);
			end else begin
				slot_s1 <= free_idx;
				old_s1  <= (OW + 1)'(N);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int j = 0; j < N; j++) begin
				rank_q[j] <= '0;
			end
		end else if (cmd.upd && ins_s1) begin
			for (int j = 0; j < N; j++) begin
				if (IW'(j) == slot_s1) begin
					rank_q[j] <= '0;
				end else if (valid_q[j] && ((OW + 1)'(rank_q[j]) < old_s1)) begin
					rank_q[j] <= rank_q[j] + IW'(1);
				end
			end
			valid_q[slot_s1] <= 1'b1;
			if (!hit_s1 && !evict_s1) begin
				occ_q <= occ_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && ins_s1) begin
			if (mode_q == lkvc_pkg::MODE_SET) begin
				val_mem_q[slot_s1] <= val_q;
			end
			if (!hit_s1) begin
				key_mem_q[slot_s1] <= key_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.upd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			hit         <= hit_s1;
			read_value  <= rd_s1;
			evicted     <= evict_s1;
			evicted_key <= evk_s1;
		end
	end

endmodule

>>> rtl/core/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller plus datapath.
//
// Command channel: raise start with mode, key and value; the word is taken at
// a rising edge where start is high and busy is low. mode 0 looks a key up,
// mode 1 stores a value under a key.
// Result channel: done is high for exactly one cycle with hit, read_value,
// evicted and evicted_key valid in that cycle. The receiver cannot stall;
// results must be taken when done is high.
// Sequence: a word passes through the parallel key compare and victim
// choice over all 16 entries in state LOOK, then the recency and entry
// update in state UPD; done is registered from UPD. busy is high in LOOK
// and UPD, so a new word is taken only once the last one is through, the
// next one at the edge that ends the cycle in which done is shown.
// Configuration: cfg_we with cfg_wdata writes the capacity in use (0 acts as
// 1, above 16 acts as 16). Write only while no word is in flight.
// Reset: arst_n clears the store to empty, all recency ranks to zero and the
// capacity to 16; the block leaves reset idle and ready to take a word.
module lru_key_value_cache (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               mode,
	input  logic signed [lkvc_pkg::KEY_W-1:0]  key,
	input  logic [lkvc_pkg::VAL_W-1:0]         value,
	input  logic                               cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]         cfg_wdata,
	output logic                               done,
	output logic                               hit,
	output logic signed [lkvc_pkg::KEY_W-1:0]  read_value,
	output logic                               evicted,
	output logic signed [lkvc_pkg::KEY_W-1:0]  evicted_key
);

	lkvc_pkg::cmd_t cmd;

	lkvc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	lkvc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mode        (mode),
		.key         (key),
		.value       (value),
		.done        (done),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule
